// ===== src/qte_pkg.sv =====
// Shared types and constants for the quintic trajectory evaluator.
package qte_pkg;

  typedef logic signed [63:0] s64_t;
  typedef logic [62:0] u63_t;

  localparam s64_t SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } cfg_wr_t;

  typedef struct packed {
    s64_t [5:0] c;
    s64_t [4:0] d1;
    s64_t [3:0] d2;
    u63_t       inv;
    logic       err;
  } coef_t;

endpackage

// ===== src/quintic_trajectory_eval.sv =====
// Quintic trajectory evaluator: Horner cell lanes for position, velocity and acceleration.
// A request passes the elapsed-time cell, then each lane's cells; each cell splits a 64x63
// product over two stages. One request per cycle is taken while the skid register is empty
// and the sequencer idle; an output register plus a skid register lets requests enter while
// a result waits. Reset loads the register defaults; after reset and after every configuration
// write the sequencer, with in_tready low, runs 63 divide steps and 19 products unless end <= start time.
module quintic_trajectory_eval import qte_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // elapsed[31:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [95:0]          out_tdata,  // position[31:0], velocity[63:32], acceleration[95:64]
  output logic [0:0]           out_tuser,  // duration_error[0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int NCELL = 5;
  localparam int NST   = 2 * NCELL + 2;
  localparam int LAST  = NST - 1;
  localparam int INV_SHIFT = 62 - FRAC_BITS;

  function automatic logic [31:0] clamp32(input s64_t x);
    logic [31:0] r;
    if (x > 64'sh7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -64'sh8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  cfg_wr_t cfg_wr;
  coef_t   coef;
  logic    busy;
  logic    en;
  logic [NST-1:0] v_r;
  s64_t    u_y;
  logic [62:0] u_s [1:2*NCELL-1];
  logic [62:0] u_r [2:2*NCELL-1];
  s64_t    lc [0:2][0:NCELL];
  s64_t    y [0:2][1:NCELL];
  logic    new_res;
  logic    take;
  logic [95:0] res_data;
  logic    ov_r, sv_r;
  logic [95:0] out_data_r, skid_data_r;
  logic    out_err_r, skid_err_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = '{we: cfg_valid, idx: cfg_index, data: cfg_data};

  qte_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .busy   (busy),
    .coef   (coef)
  );

  assign en        = !sv_r;
  assign in_tready = en && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_tvalid && in_tready};
    end
  end

  qte_cell #(.SH(30)) u_ucell (
    .clk    (clk),
    .en     (en),
    .a      ({32'b0, in_tdata}),
    .m      (coef.inv),
    .addend ('0),
    .y      (u_y)
  );

  assign u_s[1] = u_y[62:0];

  for (genvar s = 2; s <= 2 * NCELL - 1; s++) begin : g_upipe
    always_ff @(posedge clk) begin
      if (en) begin
        u_r[s] <= u_s[s-1];
      end
    end
    assign u_s[s] = u_r[s];
  end

  always_comb begin
    for (int j = 0; j <= NCELL; j++) begin
      lc[0][j] = coef.c[j];
      lc[1][j] = (j < 5) ? s64_t'(coef.d1[j]) : '0;
      lc[2][j] = (j < 4) ? s64_t'(coef.d2[j]) : '0;
    end
  end

  for (genvar L = 0; L < 3; L++) begin : g_lane
    localparam int NH = NCELL - L;
    for (genvar k = 1; k <= NCELL; k++) begin : g_cell
      localparam bit USE_U = (k <= NH);
      s64_t a_in;
      s64_t add_in;
      u63_t m_in;
      if (k == 1) begin : g_first
        assign a_in = lc[L][NH];
      end else begin : g_next
        assign a_in = y[L][k-1];
      end
      if (USE_U) begin : g_horner
        assign m_in   = u_s[2*k-1];
        assign add_in = lc[L][NH-k];
      end else begin : g_scale
        assign m_in   = coef.inv;
        assign add_in = '0;
      end
      qte_cell #(.SH(USE_U ? 32 : INV_SHIFT)) u_cell (
        .clk    (clk),
        .en     (en),
        .a      (a_in),
        .m      (m_in),
        .addend (add_in),
        .y      (y[L][k])
      );
    end
  end

  assign res_data = coef.err ? 96'b0 :
                    {clamp32(y[2][NCELL]), clamp32(y[1][NCELL]), clamp32(y[0][NCELL])};
  assign new_res  = v_r[LAST] && en;
  assign take     = ov_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (!ov_r || take) begin
      if (sv_r) begin
        ov_r <= 1'b1;
        sv_r <= 1'b0;
      end else begin
        ov_r <= new_res;
      end
    end else if (new_res) begin
      sv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || take) begin
      if (sv_r) begin
        out_data_r <= skid_data_r;
        out_err_r  <= skid_err_r;
      end else begin
        out_data_r <= res_data;
        out_err_r  <= coef.err;
      end
    end else if (new_res) begin
      skid_data_r <= res_data;
      skid_err_r  <= coef.err;
    end
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 96'b0)
    else $error("error result carries nonzero data");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sv_r) |-> $past(out_tvalid && !out_tready))
    else $error("skid register filled without a stalled output");

endmodule

// ===== src/qte_cell.sv =====
// Two-stage cell: saturating product of a by unsigned m, shifted right, plus a saturating add.
module qte_cell import qte_pkg::*; #(
  parameter int SH = 32
) (
  input  logic clk,
  input  logic en,
  input  s64_t a,
  input  u63_t m,
  input  s64_t addend,
  output s64_t y
);

  localparam logic signed [64:0] SMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;

  logic [63:0] ua;
  logic [63:0] ub;
  logic [63:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic        neg_r;
  s64_t        add_r;
  logic [127:0] prod;
  logic [127:0] shd;
  logic [62:0]  mag;
  logic signed [64:0] val;
  logic signed [64:0] sum;
  s64_t y_nxt;
  s64_t y_r;

  always_comb begin
    ua = a[63] ? 64'(-a) : 64'(a);
    ub = {1'b0, m};
    p00_nxt = ua[31:0] * ub[31:0];
    p01_nxt = ua[31:0] * ub[63:32];
    p10_nxt = ua[63:32] * ub[31:0];
    p11_nxt = ua[63:32] * ub[63:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= p00_nxt;
      p01_r <= p01_nxt;
      p10_r <= p10_nxt;
      p11_r <= p11_nxt;
      neg_r <= a[63];
      add_r <= addend;
    end
  end

  always_comb begin
    prod = {p11_r, 64'b0} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0} + {64'b0, p00_r};
    shd  = prod >> SH;
    mag  = (|shd[127:63]) ? SMAX[62:0] : shd[62:0];
    val  = neg_r ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum  = val + $signed({add_r[63], add_r});
    if (sum > SMAX65) begin
      y_nxt = SMAX;
    end else if (sum < -SMAX65) begin
      y_nxt = -SMAX;
    end else begin
      y_nxt = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

// ===== src/qte_setup.sv =====
// Configuration registers and the sequencer that derives reciprocal and coefficients.
module qte_setup import qte_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg_wr,
  output logic    busy,
  output coef_t   coef
);

  localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_POS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_POS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_VEL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_ACC  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_ACC    = 3'd7;

  localparam logic [4:0] OP_T2  = 5'd0;
  localparam logic [4:0] OP_C1  = 5'd1;
  localparam logic [4:0] OP_C2H = 5'd2;
  localparam logic [4:0] OP_X3  = 5'd3;
  localparam logic [4:0] OP_Y3  = 5'd4;
  localparam logic [4:0] OP_C3H = 5'd5;
  localparam logic [4:0] OP_X4  = 5'd6;
  localparam logic [4:0] OP_Y4  = 5'd7;
  localparam logic [4:0] OP_C4H = 5'd8;
  localparam logic [4:0] OP_X5  = 5'd9;
  localparam logic [4:0] OP_Y5  = 5'd10;
  localparam logic [4:0] OP_C5H = 5'd11;
  localparam logic [4:0] OP_D12 = 5'd12;
  localparam logic [4:0] OP_D13 = 5'd13;
  localparam logic [4:0] OP_D14 = 5'd14;
  localparam logic [4:0] OP_D15 = 5'd15;
  localparam logic [4:0] OP_D21 = 5'd16;
  localparam logic [4:0] OP_D22 = 5'd17;
  localparam logic [4:0] OP_D23 = 5'd18;
  localparam int NOPS = 19;

  localparam logic [5:0] DIV_LAST = 6'd62;
  localparam logic [1:0] PH_CAP   = 2'd2;

  localparam u63_t ONE = u63_t'(63'd1 << FRAC_BITS);
  localparam u63_t K2  = u63_t'(63'd2 << FRAC_BITS);
  localparam u63_t K3  = u63_t'(63'd3 << FRAC_BITS);
  localparam u63_t K4  = u63_t'(63'd4 << FRAC_BITS);
  localparam u63_t K5  = u63_t'(63'd5 << FRAC_BITS);
  localparam u63_t K6  = u63_t'(63'd6 << FRAC_BITS);
  localparam u63_t K12 = u63_t'(63'd12 << FRAC_BITS);
  localparam u63_t K20 = u63_t'(63'd20 << FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_MUL  = 3'b100
  } st_t;

  function automatic s64_t half(input s64_t x);
    s64_t r;
    r = (x + s64_t'({63'b0, x[63]})) >>> 1;
    return r;
  endfunction

  logic [31:0] st_time_r, en_time_r, p0_r, p1_r, v0_r, v1_r, a0_r, a1_r;
  st_t         state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  u63_t        quo_r, quo_nxt;
  logic [4:0]  op_r, op_nxt;
  logic [1:0]  ph_r, ph_nxt;
  s64_t        res_r [0:NOPS-1];

  logic        err;
  logic [31:0] t;
  logic [32:0] rem_sh;
  logic        ge;
  s64_t        t64, p0, q, v0, v1, a0, a1;
  s64_t        c2, c3, c4, c5;
  s64_t        op_a, op_add, cell_y;
  u63_t        op_m, t2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_time_r <= 32'd0;
      en_time_r <= 32'd65536;
      p0_r      <= 32'd0;
      p1_r      <= 32'd0;
      v0_r      <= 32'd0;
      v1_r      <= 32'd0;
      a0_r      <= 32'd0;
      a1_r      <= 32'd0;
    end else if (cfg_wr.we) begin
      case (cfg_wr.idx)
        REG_START_TIME: st_time_r <= cfg_wr.data;
        REG_END_TIME:   en_time_r <= cfg_wr.data;
        REG_START_POS:  p0_r      <= cfg_wr.data;
        REG_END_POS:    p1_r      <= cfg_wr.data;
        REG_START_VEL:  v0_r      <= cfg_wr.data;
        REG_END_VEL:    v1_r      <= cfg_wr.data;
        REG_START_ACC:  a0_r      <= cfg_wr.data;
        REG_END_ACC:    a1_r      <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign err = (en_time_r <= st_time_r);
  assign t   = en_time_r - st_time_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    op_nxt    = op_r;
    ph_nxt    = ph_r;
    rem_sh    = {rem_r, cnt_r == 6'd0};
    ge        = rem_sh >= {1'b0, t};
    if (cfg_wr.we) begin
      state_nxt = ST_DIV;
      cnt_nxt   = 6'd0;
      rem_nxt   = 32'd0;
      quo_nxt   = '0;
    end else begin
      case (state_r)
        ST_DIV: begin
          if (err) begin
            state_nxt = ST_IDLE;
          end else begin
            rem_nxt = ge ? 32'(rem_sh - {1'b0, t}) : rem_sh[31:0];
            quo_nxt = {quo_r[61:0], ge};
            cnt_nxt = cnt_r + 6'd1;
            if (cnt_r == DIV_LAST) begin
              state_nxt = ST_MUL;
              op_nxt    = OP_T2;
              ph_nxt    = 2'd0;
            end
          end
        end
        ST_MUL: begin
          if (ph_r == PH_CAP) begin
            ph_nxt = 2'd0;
            op_nxt = op_r + 5'd1;
            if (op_r == OP_D23) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            ph_nxt = ph_r + 2'd1;
          end
        end
        ST_IDLE: ;
        default: state_nxt = ST_DIV;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DIV;
      cnt_r   <= 6'd0;
      rem_r   <= 32'd0;
      quo_r   <= '0;
      op_r    <= OP_T2;
      ph_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      quo_r   <= quo_nxt;
      op_r    <= op_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL && ph_r == PH_CAP) begin
      res_r[op_r] <= cell_y;
    end
  end

  always_comb begin
    t64 = s64_t'({32'b0, t});
    p0  = {{32{p0_r[31]}}, p0_r};
    q   = {{32{p1_r[31]}}, p1_r} - p0;
    v0  = {{32{v0_r[31]}}, v0_r};
    v1  = {{32{v1_r[31]}}, v1_r};
    a0  = {{32{a0_r[31]}}, a0_r};
    a1  = {{32{a1_r[31]}}, a1_r};
    t2  = res_r[OP_T2][62:0];
    c2  = half(res_r[OP_C2H]);
    c3  = half(res_r[OP_C3H]);
    c4  = half(res_r[OP_C4H]);
    c5  = half(res_r[OP_C5H]);
  end

  always_comb begin
    op_a   = '0;
    op_m   = '0;
    op_add = '0;
    case (op_r)
      OP_T2:  begin op_a = t64; op_m = {31'b0, t}; end
      OP_C1:  begin op_a = v0; op_m = {31'b0, t}; end
      OP_C2H: begin op_a = a0; op_m = t2; end
      OP_X3:  begin op_a = -(v0 * 64'sd12 + v1 * 64'sd8); op_m = {31'b0, t}; end
      OP_Y3:  begin op_a = a1 - a0 * 64'sd3; op_m = t2; op_add = res_r[OP_X3]; end
      OP_C3H: begin op_a = res_r[OP_Y3]; op_m = ONE; op_add = q * 64'sd20; end
      OP_X4:  begin op_a = v0 * 64'sd16 + v1 * 64'sd14; op_m = {31'b0, t}; end
      OP_Y4:  begin op_a = a0 * 64'sd3 - a1 * 64'sd2; op_m = t2; op_add = res_r[OP_X4]; end
      OP_C4H: begin op_a = res_r[OP_Y4]; op_m = ONE; op_add = -(q * 64'sd30); end
      OP_X5:  begin op_a = -((v0 + v1) * 64'sd6); op_m = {31'b0, t}; end
      OP_Y5:  begin op_a = a1 - a0; op_m = t2; op_add = res_r[OP_X5]; end
      OP_C5H: begin op_a = res_r[OP_Y5]; op_m = ONE; op_add = q * 64'sd12; end
      OP_D12: begin op_a = c2; op_m = K2; end
      OP_D13: begin op_a = c3; op_m = K3; end
      OP_D14: begin op_a = c4; op_m = K4; end
      OP_D15: begin op_a = c5; op_m = K5; end
      OP_D21: begin op_a = c3; op_m = K6; end
      OP_D22: begin op_a = c4; op_m = K12; end
      OP_D23: begin op_a = c5; op_m = K20; end
      default: ;
    endcase
  end

  qte_cell #(.SH(FRAC_BITS)) u_mul (
    .clk    (clk),
    .en     (1'b1),
    .a      (op_a),
    .m      (op_m),
    .addend (op_add),
    .y      (cell_y)
  );

  always_comb begin
    coef.c[0]  = p0;
    coef.c[1]  = res_r[OP_C1];
    coef.c[2]  = c2;
    coef.c[3]  = c3;
    coef.c[4]  = c4;
    coef.c[5]  = c5;
    coef.d1[0] = res_r[OP_C1];
    coef.d1[1] = res_r[OP_D12];
    coef.d1[2] = res_r[OP_D13];
    coef.d1[3] = res_r[OP_D14];
    coef.d1[4] = res_r[OP_D15];
    coef.d2[0] = res_r[OP_D12];
    coef.d2[1] = res_r[OP_D21];
    coef.d2[2] = res_r[OP_D22];
    coef.d2[3] = res_r[OP_D23];
    coef.inv   = quo_r;
    coef.err   = err;
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the quintic trajectory evaluator.
`timescale 1ns / 1ps

module testbench;
  import qte_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TIME, REG_END_TIME, REG_START_POS, REG_END_POS,
    REG_START_VEL, REG_END_VEL, REG_START_ACC, REG_END_ACC
  } seg_reg_e;

  typedef struct {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
    logic        duration_error;
  } sample_t;

  localparam int FRAC = 16;
  localparam int SETTLE_CYCLES = 20;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [31:0] in_tdata = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  logic [31:0] seg_regs [8];
  sample_t expected_samples [$];
  int errors = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;

  quintic_trajectory_eval #(.FRAC_BITS(FRAC)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint mul_sat(longint a, longint b, int sh);
    logic [63:0] ua, ub;
    logic [127:0] p;
    longint mag;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, ua} * {64'd0, ub};
    p = p >> sh;
    mag = (p > 128'(SMAX)) ? SMAX : longint'(p[63:0]);
    return ((a < 0) != (b < 0)) ? -mag : mag;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > SMAX - b) return SMAX;
    if (b < 0 && a < -SMAX - b) return -SMAX;
    return a + b;
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x[31:0];
  endfunction

  function automatic longint horner_eval(longint c[6], int n, longint u);
    longint acc;
    acc = c[n-1];
    for (int i = n - 2; i >= 0; i--) acc = add_sat(mul_sat(acc, u, 32), c[i]);
    return acc;
  endfunction

  function automatic sample_t trajectory_at(logic [31:0] elapsed);
    sample_t r;
    longint t, t2, inv, u, q, p0, v0, v1, a0, a1, x;
    longint c[6], d1[6], d2[6];
    r = '{32'd0, 32'd0, 32'd0, 1'b1};
    if (seg_regs[REG_END_TIME] <= seg_regs[REG_START_TIME]) return r;
    t = longint'({32'd0, seg_regs[REG_END_TIME] - seg_regs[REG_START_TIME]});
    inv = longint'((64'd1 << 62) / 64'(t));
    u = mul_sat(longint'({32'd0, elapsed}), inv, 30);
    t2 = mul_sat(t, t, FRAC);
    p0 = longint'(signed'(seg_regs[REG_START_POS]));
    q = longint'(signed'(seg_regs[REG_END_POS])) - p0;
    v0 = longint'(signed'(seg_regs[REG_START_VEL]));
    v1 = longint'(signed'(seg_regs[REG_END_VEL]));
    a0 = longint'(signed'(seg_regs[REG_START_ACC]));
    a1 = longint'(signed'(seg_regs[REG_END_ACC]));
    c[0] = p0;
    c[1] = mul_sat(v0, t, FRAC);
    c[2] = mul_sat(a0, t2, FRAC) / 2;
    x = add_sat(mul_sat(t2, a1 - 3 * a0, FRAC), -mul_sat(t, 12 * v0 + 8 * v1, FRAC));
    c[3] = add_sat(x, 20 * q) / 2;
    x = add_sat(mul_sat(t2, 3 * a0 - 2 * a1, FRAC), mul_sat(t, 16 * v0 + 14 * v1, FRAC));
    c[4] = add_sat(x, -30 * q) / 2;
    x = add_sat(mul_sat(t2, a1 - a0, FRAC), -mul_sat(t, 6 * (v0 + v1), FRAC));
    c[5] = add_sat(x, 12 * q) / 2;
    d1 = '{default: 0};
    d2 = '{default: 0};
    for (int i = 0; i < 5; i++) d1[i] = mul_sat(c[i+1], i + 1, 0);
    for (int i = 0; i < 4; i++) d2[i] = mul_sat(c[i+2], (i + 2) * (i + 1), 0);
    r.position = clamp32(horner_eval(c, 6, u));
    r.velocity = clamp32(mul_sat(horner_eval(d1, 5, u), inv, 62 - FRAC));
    r.acceleration = clamp32(mul_sat(mul_sat(horner_eval(d2, 4, u), inv, 62 - FRAC),
                                     inv, 62 - FRAC));
    r.duration_error = 1'b0;
    return r;
  endfunction

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected result %h / %b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        e = expected_samples.pop_front();
        if (out_tdata[31:0] !== e.position) begin
          $display("%0t: position expected %h actual %h", $time, e.position, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== e.velocity) begin
          $display("%0t: velocity expected %h actual %h", $time, e.velocity,
                   out_tdata[63:32]);
          errors++;
        end
        if (out_tdata[95:64] !== e.acceleration) begin
          $display("%0t: acceleration expected %h actual %h", $time, e.acceleration,
                   out_tdata[95:64]);
          errors++;
        end
        if (out_tuser[0] !== e.duration_error) begin
          $display("%0t: duration_error expected %b actual %b", $time, e.duration_error,
                   out_tuser[0]);
          errors++;
        end
      end
    end
  end

  task automatic send_elapsed(logic [31:0] elapsed);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= elapsed;
    do @(posedge clk); while (!in_tready);
    expected_samples.push_back(trajectory_at(elapsed));
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(seg_reg_e idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    seg_regs[idx] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_segment(logic [31:0] t0, logic [31:0] t1, logic [31:0] k[6]);
    drain();
    write_reg(REG_START_TIME, t0);
    write_reg(REG_END_TIME, t1);
    for (int i = 0; i < 6; i++) write_reg(seg_reg_e'(i + 2), k[i]);
  endtask

  function automatic logic [31:0] rand_kin();
    if ($urandom_range(9) < 2) return $urandom;
    return 32'($signed($urandom_range(2 * 32'h0004_0000)) - 32'sh0004_0000);
  endfunction

  task automatic test_reset_defaults;
    send_elapsed(32'h0000_0000);
    send_elapsed(32'h0000_8000);
    send_elapsed(32'h0001_0000);
    send_elapsed(32'hFFFF_FFFF);
  endtask

  task automatic test_duration_error;
    logic [31:0] k[6] = '{32'h0001_0000, 32'h0005_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h0000_1000, 32'hFFFF_0000};
    load_segment(32'h0002_0000, 32'h0002_0000, k);
    send_elapsed(32'h0001_0000);
    send_elapsed(32'hFFFF_FFFF);
    load_segment(32'hFFFF_FFFF, 32'h0000_0000, k);
    send_elapsed(32'h0000_0000);
    send_elapsed(32'h1234_5678);
  endtask

  task automatic test_extremes;
    logic [31:0] kmax[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF};
    logic [31:0] kmin[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000};
    logic [31:0] kmove[6] = '{32'h0000_0000, 32'h000A_0000, 32'h0000_0000, 32'h0000_0000,
                              32'h0000_0000, 32'h0000_0000};
    load_segment(32'h0000_0000, 32'hFFFF_FFFF, kmax);
    send_elapsed(32'h0000_0000);
    send_elapsed(32'h7FFF_FFFF);
    send_elapsed(32'hFFFF_FFFF);
    load_segment(32'h0001_0000, 32'h0001_0001, kmin);
    send_elapsed(32'h0000_0000);
    send_elapsed(32'h0000_0001);
    send_elapsed(32'hFFFF_FFFF);
    load_segment(32'h0000_8000, 32'h0002_8000, kmove);
    send_elapsed(32'h0000_0000);
    send_elapsed(32'h0001_0000);
    send_elapsed(32'h0002_0000);
    send_elapsed(32'h0004_0000);
    send_elapsed(32'h5555_5555);
    send_elapsed(32'hAAAA_AAAA);
  endtask

  task automatic test_random_segments(int n_sets, int per_set);
    logic [31:0] t0, dur, k[6], span;
    for (int s = 0; s < n_sets; s++) begin
      t0 = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h0010_0000);
      case ($urandom_range(9))
        0: dur = $urandom_range(255);
        1: dur = $urandom;
        default: dur = $urandom_range(32'h0008_0000, 32'h0000_4000);
      endcase
      for (int i = 0; i < 6; i++) k[i] = rand_kin();
      load_segment(t0, t0 + dur, k);
      span = (dur > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : 2 * dur;
      for (int i = 0; i < per_set; i++)
        send_elapsed(($urandom_range(9) == 0) ? $urandom : $urandom_range(span));
    end
  endtask

  initial begin
    seg_regs = '{32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    in_idle_pct = 13;
    out_idle_pct = 83;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_duration_error();
    test_extremes();
    test_random_segments(5, 50);
    in_idle_pct = 83;
    out_idle_pct = 13;
    test_random_segments(5, 50);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_segments(5, 50);
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
